// ===== rtl/raf_pkg.sv =====
`timescale 1ns / 1ps

package raf_pkg;

    // Atlas geometry and table sizes.
    localparam int ATLAS_WIDTH     = 1024;
    localparam int ATLAS_HEIGHT    = 1024;
    localparam int GRID_STEP       = 16;
    localparam int NUM_ATLASES     = 4;
    localparam int SLOTS_PER_ATLAS = 64;

    localparam int ATLAS_BITS = $clog2(NUM_ATLASES);
    localparam int SLOT_BITS  = $clog2(SLOTS_PER_ATLAS);
    localparam int ENTRY_BITS = ATLAS_BITS + SLOT_BITS;
    localparam int TOTAL_SLOTS = NUM_ATLASES * SLOTS_PER_ATLAS;
    localparam int POS_BITS   = 10;
    localparam int SIZE_BITS  = 11;
    localparam int SUM_BITS   = 13;
    localparam int RECT_BITS  = 2 * POS_BITS + 2 * SIZE_BITS;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic do_free;
        logic start_atlas;
        logic scan_issue;
        logic next_corner;
        logic next_atlas;
        logic place;
        logic open_atlas;
        logic fail;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic atl_in_range;
        logic can_open;
        logic iss_done;
        logic hit;
        logic free_found;
        logic scan_over;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/raf_ctrl.sv =====
`timescale 1ns / 1ps

module raf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  raf_pkg::dp_status_t stat,
    output raf_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FREE = 3'd1;
    localparam logic [2:0] S_ATL  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    // Sequencing of one request.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ATL;
                end
            end
            S_ATL:
            begin
                if (stat.is_free)
                begin
                    state_next = S_FREE;
                end
                else if (stat.atl_in_range)
                begin
                    cmd.start_atlas = 1'b1;
                    state_next      = S_SCAN;
                end
                else if (stat.out_free)
                begin
                    cmd.open_atlas = stat.can_open;
                    cmd.fail       = !stat.can_open;
                    state_next     = S_IDLE;
                end
            end
            S_FREE:
            begin
                if (stat.out_free)
                begin
                    cmd.do_free = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.iss_done)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                end
            end
            S_EVAL:
            begin
                if (!stat.free_found || (stat.hit && stat.scan_over))
                begin
                    cmd.next_atlas = 1'b1;
                    state_next     = S_ATL;
                end
                else if (stat.hit)
                begin
                    cmd.next_corner = 1'b1;
                    state_next      = S_SCAN;
                end
                else if (stat.out_free)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The scan only runs between a request beat and its result.
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> in_stall)
        else $error("scan while accepting");
    a_place_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> (state_reg == S_EVAL) && stat.free_found && !stat.hit)
        else $error("place without free corner and slot");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.place, cmd.open_atlas, cmd.fail, cmd.do_free}) <= 1)
        else $error("two results in one cycle");

endmodule

// ===== rtl/raf_dpath.sv =====
`timescale 1ns / 1ps

module raf_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  raf_pkg::ctrl_cmd_t  cmd,
    output raf_pkg::dp_status_t stat,
    input  logic                in_cmd,
    input  logic [10:0]         in_width,
    input  logic [10:0]         in_height,
    input  logic [1:0]          in_atlas,
    input  logic [5:0]          in_slot,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          out_status,
    output logic [1:0]          out_atlas,
    output logic [5:0]          out_slot,
    output logic [9:0]          out_x,
    output logic [9:0]          out_y
);

    localparam int AB  = raf_pkg::ATLAS_BITS;
    localparam int SB  = raf_pkg::SLOT_BITS;
    localparam int EB  = raf_pkg::ENTRY_BITS;
    localparam int PB  = raf_pkg::POS_BITS;
    localparam int ZB  = raf_pkg::SIZE_BITS;
    localparam int UB  = raf_pkg::SUM_BITS;
    localparam int RB  = raf_pkg::RECT_BITS;

    // Request registers.
    logic          cmd_reg;
    logic [ZB-1:0] w_reg;
    logic [ZB-1:0] h_reg;
    logic [AB-1:0] asel_reg;
    logic [SB-1:0] ssel_reg;

    // Scan state.
    logic [AB:0]   atl_reg;
    logic [AB:0]   in_use_reg;
    logic [PB-1:0] x_reg;
    logic [PB-1:0] y_reg;
    logic [SB:0]   iss_reg;
    logic          cmp_en_reg;
    logic [SB-1:0] cmp_slot_reg;
    logic          hit_reg;
    logic          free_found_reg;
    logic [SB-1:0] free_slot_reg;

    // Entry store.
    logic [RB-1:0]   mem [raf_pkg::TOTAL_SLOTS];
    logic [raf_pkg::TOTAL_SLOTS-1:0] valid_reg;
    logic [RB-1:0]   rd_reg;
    logic            rdv_reg;
    logic [EB-1:0]   rd_addr;
    logic            mem_we;
    logic [EB-1:0]   wr_addr;
    logic [RB-1:0]   wr_data;
    logic [EB-1:0]   free_addr;

    // Result register.
    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [AB-1:0] oatl_reg;
    logic [SB-1:0] oslot_reg;
    logic [PB-1:0] ox_reg;
    logic [PB-1:0] oy_reg;

    logic [PB-1:0] rx;
    logic [PB-1:0] ry;
    logic [ZB-1:0] rw;
    logic [ZB-1:0] rh;
    logic          overlap;
    logic [UB-1:0] nx;
    logic [UB-1:0] ny;
    logic          wrap;
    logic          produce;

    assign rd_addr   = {atl_reg[AB-1:0], iss_reg[SB-1:0]};
    assign free_addr = {asel_reg, ssel_reg};
    assign {rx, ry, rw, rh} = rd_reg;

    // Overlap of the current corner with the entry just read.
    always_comb
    begin
        overlap = !(UB'(x_reg) >= UB'(rx) + UB'(rw)) &&
                  !(UB'(x_reg) + UB'(w_reg) <= UB'(rx)) &&
                  !(UB'(y_reg) >= UB'(ry) + UB'(rh)) &&
                  !(UB'(y_reg) + UB'(h_reg) <= UB'(ry));
    end

    // Next grid corner and the wrap at the end of a row.
    always_comb
    begin
        nx   = UB'(x_reg) + UB'(raf_pkg::GRID_STEP);
        wrap = (nx + UB'(w_reg)) >= UB'(raf_pkg::ATLAS_WIDTH);
        ny   = wrap ? UB'(y_reg) + UB'(raf_pkg::GRID_STEP) : UB'(y_reg);
    end

    always_comb
    begin
        stat.is_free      = (cmd_reg == raf_pkg::CMD_FREE);
        stat.atl_in_range = (atl_reg < in_use_reg);
        stat.can_open     = (in_use_reg < (AB+1)'(raf_pkg::NUM_ATLASES));
        stat.iss_done     = (iss_reg == (SB+1)'(raf_pkg::SLOTS_PER_ATLAS));
        stat.hit          = hit_reg;
        stat.free_found   = free_found_reg;
        stat.scan_over    = (ny + UB'(h_reg)) >= UB'(raf_pkg::ATLAS_HEIGHT);
        stat.out_free     = !out_valid_reg || !out_stall;
    end

    // Entry write on a placement or an opened atlas.
    always_comb
    begin
        mem_we  = cmd.place || cmd.open_atlas;
        wr_addr = cmd.place ? {atl_reg[AB-1:0], free_slot_reg}
                            : {in_use_reg[AB-1:0], SB'(0)};
        wr_data = cmd.place ? {x_reg, y_reg, w_reg, h_reg}
                            : {PB'(0), PB'(0), w_reg, h_reg};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // Request capture and scan registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= raf_pkg::CMD_ALLOC;
            w_reg          <= '0;
            h_reg          <= '0;
            asel_reg       <= '0;
            ssel_reg       <= '0;
            atl_reg        <= '0;
            in_use_reg     <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            iss_reg        <= '0;
            cmp_en_reg     <= 1'b0;
            cmp_slot_reg   <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            rdv_reg        <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            rdv_reg      <= valid_reg[rd_addr];
            cmp_en_reg   <= cmd.scan_issue;
            cmp_slot_reg <= iss_reg[SB-1:0];
            if (cmd.load)
            begin
                cmd_reg  <= in_cmd;
                w_reg    <= in_width;
                h_reg    <= in_height;
                asel_reg <= in_atlas;
                ssel_reg <= in_slot;
                atl_reg  <= '0;
            end
            if (cmd.start_atlas)
            begin
                x_reg          <= '0;
                y_reg          <= '0;
                iss_reg        <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            if (cmd.scan_issue)
            begin
                iss_reg <= iss_reg + (SB+1)'(1);
            end
            if (cmp_en_reg)
            begin
                if (rdv_reg && overlap)
                begin
                    hit_reg <= 1'b1;
                end
                if (!rdv_reg && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= cmp_slot_reg;
                end
            end
            if (cmd.next_corner)
            begin
                x_reg   <= wrap ? PB'(0) : nx[PB-1:0];
                y_reg   <= ny[PB-1:0];
                iss_reg <= '0;
                hit_reg <= 1'b0;
            end
            if (cmd.next_atlas)
            begin
                atl_reg <= atl_reg + (AB+1)'(1);
            end
            if (cmd.open_atlas)
            begin
                in_use_reg <= in_use_reg + (AB+1)'(1);
            end
            if (mem_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.do_free)
            begin
                valid_reg[free_addr] <= 1'b0;
            end
        end
    end

    // Result register; a new beat loads only once the previous one is taken.
    assign produce = cmd.place || cmd.open_atlas || cmd.fail || cmd.do_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= produce || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            status_reg <= raf_pkg::ST_DONE;
            oatl_reg   <= '0;
            oslot_reg  <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            if (cmd.place)
            begin
                oatl_reg  <= atl_reg[AB-1:0];
                oslot_reg <= free_slot_reg;
                ox_reg    <= x_reg;
                oy_reg    <= y_reg;
            end
            if (cmd.open_atlas)
            begin
                oatl_reg <= in_use_reg[AB-1:0];
            end
            if (cmd.fail)
            begin
                status_reg <= raf_pkg::ST_FAIL;
            end
            if (cmd.do_free && !valid_reg[free_addr])
            begin
                status_reg <= raf_pkg::ST_EMPTY;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_atlas  = oatl_reg;
    assign out_slot   = oslot_reg;
    assign out_x      = ox_reg;
    assign out_y      = oy_reg;

    a_in_use_max: assert property (@(posedge clk) disable iff (!rst_n)
        in_use_reg <= (AB+1)'(raf_pkg::NUM_ATLASES))
        else $error("too many atlases in use");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |-> !stat.iss_done)
        else $error("read past the slot table");
    a_place_sets: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(wr_addr)])
        else $error("placed entry not marked valid");

endmodule

// ===== rtl/rect_atlas_first_fit_allocator_core.sv =====
// A free request passes the S_ATL and S_FREE states, then loads its result beat once the output register is free.
// An allocation visits the atlases in use in turn and opens a new one if none fits; each tested
// grid corner takes 64 slot reads, a drain of the last read and a decision in S_EVAL.
// Throughput: one request at a time; the next beat is taken once the result is loaded.
// Reset: asynchronous, active low; all valid bits and the atlas count clear at once.
`timescale 1ns / 1ps

module rect_atlas_first_fit_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [10:0] req_width,
    input  logic [10:0] req_height,
    input  logic [1:0]  atlas_sel,
    input  logic [5:0]  slot_sel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [1:0]  atlas_index,
    output logic [5:0]  slot_index,
    output logic [9:0]  pos_x,
    output logic [9:0]  pos_y
);

    raf_pkg::ctrl_cmd_t  ctl;
    raf_pkg::dp_status_t dst;

    raf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (dst),
        .cmd      (ctl)
    );

    raf_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctl),
        .stat       (dst),
        .in_cmd     (cmd),
        .in_width   (req_width),
        .in_height  (req_height),
        .in_atlas   (atlas_sel),
        .in_slot    (slot_sel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_status (status),
        .out_atlas  (atlas_index),
        .out_slot   (slot_index),
        .out_x      (pos_x),
        .out_y      (pos_y)
    );

endmodule
